[design/cfpa_pkg.sv]
package cfpa_pkg;

   localparam int PageBits  = 12;
   localparam int PageCount = 4096;
   localparam int ColorBits = 4;
   localparam int ColorCount = 16;
   localparam int CountBits = 13;
   localparam int ZeroTrigger = 8;
   localparam int ShadeBits = ColorBits + 1;
   localparam logic [CountBits-1:0] LowReset  = 13'd32;
   localparam logic [CountBits-1:0] HighReset = 13'd1024;

   // link value with the top bit set marks the end of a chain
   typedef logic [PageBits:0] link_type;
   localparam link_type NilLink = '1;

   typedef enum logic [2:0] {
      OP_ALLOC_ANY    = 3'd0,
      OP_ALLOC_ZEROED = 3'd1,
      OP_FREE_PAGE    = 3'd2,
      OP_INSERT_ZERO  = 3'd3,
      OP_UNLINK       = 3'd4,
      OP_ZERO_ACK     = 3'd5,
      OP_SPARE6       = 3'd6,
      OP_SPARE7       = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_EMPTY   = 2'd1,
      ERR_UNLINKED = 2'd2
   } err_type;

   localparam logic [1:0] PlaceNone = 2'd0;
   localparam logic [1:0] PlaceZero = 2'd1;
   localparam logic [1:0] PlaceFree = 2'd2;

   localparam logic [0:0] CsrLow  = 1'b0;
   localparam logic [0:0] CsrHigh = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_READ,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load;
      logic lookup;
      logic read;
      logic update;
      logic done;
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } status_type;

endpackage

[design/cfpa_control.sv]
module cfpa_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  cfpa_pkg::status_type  status,
   output cfpa_pkg::cmd_type     cmd
);
   import cfpa_pkg::*;

   state_type state_ff, state_in;

   // advance through the step sequence
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid && !status.clearing) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_READ;
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_RESULT;
         ST_RESULT: if (rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // drive commands; hold off requests while the placement store clears
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !status.clearing;
            cmd.load = req_tvalid && !status.clearing;
         end
         ST_LOOKUP: cmd.lookup = 1'b1;
         ST_READ:   cmd.read = 1'b1;
         ST_UPDATE: cmd.update = 1'b1;
         ST_RESULT: begin
            rsp_tvalid = 1'b1;
            cmd.done = rsp_tready;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

[design/cfpa_datapath.sv]
module cfpa_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  cfpa_pkg::cmd_type                 cmd,
   input  logic [2:0]                        in_op,
   input  logic [cfpa_pkg::PageBits-1:0]     in_page,
   input  logic [cfpa_pkg::ColorBits-1:0]    in_color,
   input  logic                              csr_write,
   input  logic                              csr_index,
   input  logic [cfpa_pkg::CountBits-1:0]    csr_data,
   output logic [31:0]                       result,
   output cfpa_pkg::status_type              status
);
   import cfpa_pkg::*;

   // link memories: list next/prev, colour next/prev
   link_type lnext_mem [PageCount];
   link_type lprev_mem [PageCount];
   link_type cnext_mem [PageCount];
   link_type cprev_mem [PageCount];
   // placement store, cleared by a pass over every entry after reset
   logic [1:0] place_mem [PageCount];
   logic [PageBits:0] clr_ff;

   link_type pfirst_ff [2];
   link_type plast_ff [2];
   logic [CountBits-1:0] ptotal_ff [2];
   link_type sfirst_ff [2*ColorCount];
   link_type slast_ff [2*ColorCount];
   logic [CountBits-1:0] avail_ff;
   logic busy_ff, low_ff, high_ff;
   logic [CountBits-1:0] lowthr_ff, highthr_ff;

   logic [2:0] op_ff;
   logic [PageBits-1:0] page_ff;
   logic [ColorBits-1:0] color_ff;
   link_type got_ff;
   logic needz_ff;
   logic [1:0] err_ff;
   logic zreq_ff;
   logic [1:0] place_rd_ff;
   link_type ln_ff, lp_ff, cn_ff, cp_ff;

   // choose the page in lookup
   link_type cz, cf, pick;
   logic pick_nz;
   always_comb begin
      cz = sfirst_ff[{1'b0, color_ff}];
      cf = sfirst_ff[{1'b1, color_ff}];
      pick = NilLink;
      pick_nz = 1'b0;
      if (op_type'(op_ff) == OP_ALLOC_ANY) begin
         priority if (!cf[PageBits]) pick = cf;
         else if (!cz[PageBits]) pick = cz;
         else if (!pfirst_ff[1][PageBits]) pick = pfirst_ff[1];
         else pick = pfirst_ff[0];
      end else if (op_type'(op_ff) == OP_ALLOC_ZEROED) begin
         priority if (!cz[PageBits]) pick = cz;
         else if (!pfirst_ff[0][PageBits]) pick = pfirst_ff[0];
         else begin
            pick = cf[PageBits] ? pfirst_ff[1] : cf;
            pick_nz = !pick[PageBits];
         end
      end else begin
         pick = {1'b0, page_ff};
      end
   end

   logic [PageBits-1:0] tgt;
   assign tgt = got_ff[PageBits-1:0];
   logic [1:0] place_now;
   assign place_now = place_rd_ff;

   logic is_alloc;
   assign is_alloc = (op_type'(op_ff) == OP_ALLOC_ANY) || (op_type'(op_ff) == OP_ALLOC_ZEROED);

   // update helpers
   logic do_add, do_rm, add_free;
   logic rm_pool;
   logic [ShadeBits-1:0] s_add, s_rm;
   logic [CountBits-1:0] avail_up, free_after;
   always_comb begin
      do_add = 1'b0;
      do_rm = 1'b0;
      add_free = (op_type'(op_ff) == OP_FREE_PAGE);
      if ((op_type'(op_ff) == OP_FREE_PAGE || op_type'(op_ff) == OP_INSERT_ZERO)
          && place_now == PlaceNone)
         do_add = 1'b1;
      if ((is_alloc || op_type'(op_ff) == OP_UNLINK) && !got_ff[PageBits]
          && place_now != PlaceNone)
         do_rm = 1'b1;
      rm_pool = (place_now == PlaceFree);
      s_add = {add_free, tgt[ColorBits-1:0]};
      s_rm = {rm_pool, tgt[ColorBits-1:0]};
      avail_up = avail_ff + 1'b1;
      free_after = ptotal_ff[1] + 1'b1;
   end

   // step the clearing pass, one entry a cycle
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (!clr_ff[PageBits]) clr_ff <= clr_ff + 1'b1;
   end
   assign status.clearing = !clr_ff[PageBits];

   // placement store read/write
   always_ff @(posedge clock) begin
      if (cmd.lookup) place_rd_ff <= 2'b00;
      if (cmd.read) place_rd_ff <= place_mem[tgt];
      if (!clr_ff[PageBits]) place_mem[clr_ff[PageBits-1:0]] <= PlaceNone;
      else if (cmd.update && do_add) place_mem[tgt] <= add_free ? PlaceFree : PlaceZero;
      else if (cmd.update && do_rm) place_mem[tgt] <= PlaceNone;
   end

   // link reads
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         ln_ff <= lnext_mem[tgt];
         lp_ff <= lprev_mem[tgt];
         cn_ff <= cnext_mem[tgt];
         cp_ff <= cprev_mem[tgt];
      end
   end

   // link writes: at most two writes per memory, done in one update
   link_type p_last, s_last, p_first, s_first;
   always_comb begin
      p_last = plast_ff[add_free];
      s_last = slast_ff[s_add];
      p_first = pfirst_ff[add_free];
      s_first = sfirst_ff[s_add];
   end

   always_ff @(posedge clock) begin
      if (cmd.update && do_add) begin
         if (add_free) begin
            if (!p_last[PageBits]) lnext_mem[p_last[PageBits-1:0]] <= {1'b0, tgt};
            if (!s_last[PageBits]) cnext_mem[s_last[PageBits-1:0]] <= {1'b0, tgt};
            lnext_mem[tgt] <= NilLink;
            lprev_mem[tgt] <= p_last;
            cnext_mem[tgt] <= NilLink;
            cprev_mem[tgt] <= s_last;
         end else begin
            if (!p_first[PageBits]) lprev_mem[p_first[PageBits-1:0]] <= {1'b0, tgt};
            if (!s_first[PageBits]) cprev_mem[s_first[PageBits-1:0]] <= {1'b0, tgt};
            lnext_mem[tgt] <= p_first;
            lprev_mem[tgt] <= NilLink;
            cnext_mem[tgt] <= s_first;
            cprev_mem[tgt] <= NilLink;
         end
      end else if (cmd.update && do_rm) begin
         if (!ln_ff[PageBits]) lprev_mem[ln_ff[PageBits-1:0]] <= lp_ff;
         if (!lp_ff[PageBits]) lnext_mem[lp_ff[PageBits-1:0]] <= ln_ff;
         if (!cn_ff[PageBits]) cprev_mem[cn_ff[PageBits-1:0]] <= cp_ff;
         if (!cp_ff[PageBits]) cnext_mem[cp_ff[PageBits-1:0]] <= cn_ff;
      end
   end

   // heads, tails, counts and events
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            pfirst_ff[i] <= NilLink;
            plast_ff[i] <= NilLink;
            ptotal_ff[i] <= '0;
         end
         for (int i = 0; i < 2*ColorCount; i++) begin
            sfirst_ff[i] <= NilLink;
            slast_ff[i] <= NilLink;
         end
         avail_ff <= '0;
         busy_ff <= 1'b0;
         low_ff <= 1'b0;
         high_ff <= 1'b0;
         lowthr_ff <= LowReset;
         highthr_ff <= HighReset;
      end else begin
         if (csr_write) begin
            if (csr_index == CsrLow) lowthr_ff <= csr_data;
            else highthr_ff <= csr_data;
         end
         if (cmd.update && do_add) begin
            if (add_free) begin
               if (p_last[PageBits]) pfirst_ff[1] <= {1'b0, tgt};
               plast_ff[1] <= {1'b0, tgt};
               if (s_last[PageBits]) sfirst_ff[s_add] <= {1'b0, tgt};
               slast_ff[s_add] <= {1'b0, tgt};
               if (free_after >= CountBits'(ZeroTrigger) && !busy_ff) busy_ff <= 1'b1;
            end else begin
               if (p_first[PageBits]) plast_ff[0] <= {1'b0, tgt};
               pfirst_ff[0] <= {1'b0, tgt};
               if (s_first[PageBits]) slast_ff[s_add] <= {1'b0, tgt};
               sfirst_ff[s_add] <= {1'b0, tgt};
            end
            ptotal_ff[add_free] <= ptotal_ff[add_free] + 1'b1;
            avail_ff <= avail_up;
            if (avail_up == lowthr_ff) low_ff <= 1'b0;
            else if (avail_up == highthr_ff) high_ff <= 1'b1;
         end else if (cmd.update && do_rm) begin
            if (ln_ff[PageBits]) plast_ff[rm_pool] <= lp_ff;
            if (lp_ff[PageBits]) pfirst_ff[rm_pool] <= ln_ff;
            if (cn_ff[PageBits]) slast_ff[s_rm] <= cp_ff;
            if (cp_ff[PageBits]) sfirst_ff[s_rm] <= cn_ff;
            if (ptotal_ff[rm_pool] != '0) ptotal_ff[rm_pool] <= ptotal_ff[rm_pool] - 1'b1;
            if (avail_ff == highthr_ff) high_ff <= 1'b0;
            else if (avail_ff == lowthr_ff) low_ff <= 1'b1;
            if (avail_ff != '0) avail_ff <= avail_ff - 1'b1;
         end
         if (cmd.update && op_type'(op_ff) == OP_ZERO_ACK) busy_ff <= 1'b0;
      end
   end

   // capture transaction and per-step result
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= in_op;
         page_ff <= in_page;
         color_ff <= in_color;
      end
      if (cmd.lookup) begin
         got_ff <= pick;
         needz_ff <= pick_nz;
      end
      if (cmd.update) begin
         err_ff <= ERR_NONE;
         zreq_ff <= 1'b0;
         if (is_alloc && !do_rm) begin
            got_ff <= NilLink;
            needz_ff <= 1'b0;
            err_ff <= ERR_EMPTY;
         end
         if (op_type'(op_ff) == OP_UNLINK && !do_rm) err_ff <= ERR_UNLINKED;
         if (do_add && add_free && free_after >= CountBits'(ZeroTrigger) && !busy_ff)
            zreq_ff <= 1'b1;
      end
   end

   logic [PageBits-1:0] out_page;
   logic out_granted;
   assign out_granted = is_alloc && !got_ff[PageBits];
   assign out_page = out_granted ? tgt : '0;
   // granted_page, granted, needs_zeroing, error_code, low, high, zreq, available
   assign result = {avail_ff, zreq_ff, high_ff, low_ff, err_ff, needz_ff,
                    out_granted, out_page};
endmodule

[design/colored_free_page_allocator_unit.sv]
// Sequence: a req transaction passes through lookup, read, update and result before its rsp transaction.
// Issue: a new req transaction is taken only after the rsp transaction completes and control is back
// in idle; the link memory read-then-write sequence and the return to idle set this.
// Reset: synchronous, active high; lists empty, counts and events cleared, thresholds
// 32 and 1024. The placement store then clears in a pass over every entry with req_tready low.
module colored_free_page_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // operation[2:0], page[14:3], color[18:15], zeros
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // granted_page[11:0], granted[12], needs_zeroing[13],
                                   // error_code[15:14], low[16], high[17], zreq[18],
                                   // available_pages[31:19]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [12:0] csr_data
);
   import cfpa_pkg::*;

   cmd_type cmd;
   status_type status;
   logic [31:0] result;

   assign csr_ready = 1'b1;

   cfpa_control u_control (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .status, .cmd
   );

   cfpa_datapath u_datapath (
      .clock, .reset, .cmd,
      .in_op(req_tdata[2:0]),
      .in_page(req_tdata[14:3]),
      .in_color(req_tdata[18:15]),
      .csr_write(csr_valid),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .result(result),
      .status(status)
   );

   assign rsp_tdata = result;

   logic unused_bits;
   assign unused_bits = ^req_tdata[23:19];

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.lookup, cmd.read, cmd.update, cmd.done}))
      else $error("more than one step command");
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12] |-> rsp_tdata[15:14] == ERR_NONE)
      else $error("grant with error");
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("back to back result");
endmodule
